[rtl/core/etach_pkg.sv]
// shared constants, codes and controller/datapath types for the tachometer
package etach_pkg;

    localparam int THRESH_W   = 10;
    localparam int TIMEOUT_W  = 24;
    localparam int SAMPLE_W   = 10;
    localparam int RPM_W      = 21;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam int TICK_US    = 1;
    localparam int TIMER_BITS = 24;
    localparam int ELAPSED_W  = 24;
    localparam int US_W       = TIMER_BITS + $clog2(TICK_US + 1);

    localparam logic [ELAPSED_W-1:0]  ELAPSED_MAX = '1;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX   = '1;

    // 30000000 rpm*us scaled by 256
    localparam int          NUM_W   = 33;
    localparam logic [NUM_W-1:0] RPM_Q8_NUM = 33'd7680000000;
    localparam logic [US_W-1:0]  MIN_PERIOD_US = US_W'(6000);
    localparam logic [US_W-1:0]  REM_INIT = US_W'(RPM_Q8_NUM >> RPM_W);
    localparam int          DIV_CNT_W = $clog2(RPM_W);

    localparam logic [THRESH_W-1:0]  THRESH_RST  = 10'd512;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 24'd100000;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd1;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_NEW     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_HELD    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TIMEOUT = 2'd2;

    typedef struct packed {
        logic                start;
        logic                tick;
        logic                per_en;
        logic                clr_period;
        logic                div_start;
        logic                div_step;
        logic                load_out;
        logic [STATUS_W-1:0] out_status;
    } t_cmd;

    typedef struct packed {
        logic above;
        logic below;
        logic timeout_hit;
        logic short_period;
        logic div_done;
    } t_sts;

endpackage

[rtl/core/etach_in_if.sv]
// request channel carrying start and sample ticks
interface etach_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [etach_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink   (input valid, input kind, input sample, output ready);
endinterface

[rtl/core/etach_out_if.sv]
// result channel carrying speed and status
interface etach_out_if;
    logic                           valid;
    logic                           ready;
    logic [etach_pkg::RPM_W-1:0]    rpm_q8;
    logic [etach_pkg::STATUS_W-1:0] status;

    modport source (output valid, output rpm_q8, output status, input ready);
    modport sink   (input valid, input rpm_q8, input status, output ready);
endinterface

[rtl/core/encoder_period_tachometer.sv]
// top level of the period-measuring tachometer
// A start request arms a measurement; each sample request is one tick carrying a ten-bit
// sensor reading. The block waits for the beam above, below, above and below the threshold;
// the ticks between the start and end marks form the period, and the speed is reported as
// 30000000/(ticks*TICK_US) rpm in unsigned Q13.8 (status 0), the last speed for a period
// under 6000 us (status 1), or 0 on timeout (status 2). Start requests and ticks that do not
// end a measurement leave the block ready for the next request. A tick that ends a normal
// measurement starts a restoring divider that produces one quotient bit per cycle; the next
// request is taken once the quotient is loaded into the result register. A request is also
// taken while a result waits, if the result register is freed in the same cycle or is empty.
module encoder_period_tachometer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    etach_in_if.sink                          i_in,
    etach_out_if.source                       o_out,
    input  logic                              i_cfg_we,
    input  logic [etach_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [etach_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    etach_pkg::t_cmd cmd;
    etach_pkg::t_sts sts;

    etach_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_kind      (i_in.kind),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    etach_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_in.sample),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_rpm_q8   (o_out.rpm_q8),
        .o_status   (o_out.status)
    );

endmodule

[rtl/core/etach_ctrl.sv]
// measurement phase and sequencing controller
module etach_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_kind,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output etach_pkg::t_cmd   o_cmd,
    input  etach_pkg::t_sts   i_sts
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_HIGH1 = 3'd1;
    localparam logic [2:0] PH_LOW1  = 3'd2;
    localparam logic [2:0] PH_HIGH2 = 3'd3;
    localparam logic [2:0] PH_LOW2  = 3'd4;

    localparam logic [1:0] SEQ_IDLE = 2'd0;
    localparam logic [1:0] SEQ_DIV  = 2'd1;
    localparam logic [1:0] SEQ_OUT  = 2'd2;

    logic [2:0] r_phase, n_phase;
    logic [1:0] r_seq, n_seq;
    logic       r_out_valid, n_out_valid;
    logic       in_ready;
    logic       accept;
    logic       stay;
    logic       out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign in_ready   = (r_seq == SEQ_IDLE) && out_free;
    assign accept     = i_in_valid && in_ready;
    assign o_in_ready = in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_phase = r_phase;
        n_seq   = r_seq;
        stay    = ((r_phase == PH_HIGH1) || (r_phase == PH_HIGH2)) ? i_sts.above : i_sts.below;
        case (r_seq)
            SEQ_IDLE: begin
                if (accept) begin
                    if (i_kind == etach_pkg::KIND_START) begin
                        o_cmd.start = 1'b1;
                        n_phase     = PH_HIGH1;
                    end else if (r_phase != PH_IDLE) begin
                        o_cmd.tick   = 1'b1;
                        o_cmd.per_en = (r_phase == PH_HIGH2) || (r_phase == PH_LOW2);
                        if (stay) begin
                            if (i_sts.timeout_hit) begin
                                o_cmd.load_out   = 1'b1;
                                o_cmd.out_status = etach_pkg::STATUS_TIMEOUT;
                                n_phase          = PH_IDLE;
                            end
                        end else if (r_phase == PH_LOW2) begin
                            n_phase = PH_IDLE;
                            if (i_sts.short_period) begin
                                o_cmd.load_out   = 1'b1;
                                o_cmd.out_status = etach_pkg::STATUS_HELD;
                            end else begin
                                o_cmd.div_start = 1'b1;
                                n_seq           = SEQ_DIV;
                            end
                        end else begin
                            o_cmd.clr_period = (r_phase == PH_LOW1);
                            n_phase          = r_phase + 3'd1;
                        end
                    end
                end
            end
            SEQ_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_seq = SEQ_OUT;
                end
            end
            SEQ_OUT: begin
                if (out_free) begin
                    o_cmd.load_out   = 1'b1;
                    o_cmd.out_status = etach_pkg::STATUS_NEW;
                    n_seq            = SEQ_IDLE;
                end
            end
            default: begin
                n_seq = SEQ_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_seq       <= SEQ_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/core/etach_dp.sv]
// counters, config registers, serial divider and result register
module etach_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [etach_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [etach_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [etach_pkg::SAMPLE_W-1:0]    i_sample,
    input  etach_pkg::t_cmd                   i_cmd,
    output etach_pkg::t_sts                   o_sts,
    output logic [etach_pkg::RPM_W-1:0]       o_rpm_q8,
    output logic [etach_pkg::STATUS_W-1:0]    o_status
);

    logic [etach_pkg::THRESH_W-1:0]   r_threshold;
    logic [etach_pkg::TIMEOUT_W-1:0]  r_timeout;
    logic [etach_pkg::ELAPSED_W-1:0]  r_elapsed, n_elapsed_inc;
    logic [etach_pkg::TIMER_BITS-1:0] r_period, n_period_inc, n_period;
    logic [etach_pkg::US_W-1:0]       us_next;
    logic [etach_pkg::RPM_W-1:0]      r_last;
    logic [etach_pkg::US_W-1:0]       r_div;
    logic [etach_pkg::US_W-1:0]       r_rem;
    logic [etach_pkg::RPM_W-1:0]      r_quo;
    logic [etach_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [etach_pkg::US_W+1:0]       trial;
    logic [etach_pkg::RPM_W-1:0]      r_rpm;
    logic [etach_pkg::STATUS_W-1:0]   r_status;

    assign n_elapsed_inc = (r_elapsed == etach_pkg::ELAPSED_MAX) ? r_elapsed
                                                                 : r_elapsed + 1'b1;
    assign n_period_inc  = (r_period == etach_pkg::TIMER_MAX) ? r_period : r_period + 1'b1;
    assign n_period      = i_cmd.per_en ? n_period_inc : r_period;
    // period including the tick that ends the last wait
    assign us_next       = etach_pkg::US_W'(n_period_inc) * etach_pkg::US_W'(etach_pkg::TICK_US);

    assign trial = {1'b0, r_rem, r_quo[etach_pkg::RPM_W-1]} - {2'b00, r_div};

    assign o_sts.above        = i_sample > r_threshold;
    assign o_sts.below        = i_sample < r_threshold;
    assign o_sts.timeout_hit  = r_elapsed >= r_timeout;
    assign o_sts.short_period = us_next < etach_pkg::MIN_PERIOD_US;
    assign o_sts.div_done     = (r_cnt == '0);

    assign o_rpm_q8 = r_rpm;
    assign o_status = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= etach_pkg::THRESH_RST;
            r_timeout   <= etach_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == etach_pkg::CFG_THRESHOLD) begin
                r_threshold <= i_cfg_data[etach_pkg::THRESH_W-1:0];
            end
            if (i_cfg_idx == etach_pkg::CFG_TIMEOUT) begin
                r_timeout <= i_cfg_data[etach_pkg::TIMEOUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_period  <= '0;
            r_last    <= '0;
        end else begin
            if (i_cmd.start) begin
                r_elapsed <= '0;
                r_period  <= '0;
            end else if (i_cmd.tick) begin
                r_elapsed <= n_elapsed_inc;
                r_period  <= i_cmd.clr_period ? '0 : n_period;
            end
            if (i_cmd.load_out && (i_cmd.out_status == etach_pkg::STATUS_NEW)) begin
                r_last <= r_quo;
            end
        end
    end

    // restoring divide, one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div <= us_next;
            r_rem <= etach_pkg::REM_INIT;
            r_quo <= etach_pkg::RPM_Q8_NUM[etach_pkg::RPM_W-1:0];
            r_cnt <= etach_pkg::DIV_CNT_W'(etach_pkg::RPM_W - 1);
        end else if (i_cmd.div_step) begin
            if (!trial[etach_pkg::US_W+1]) begin
                r_rem <= trial[etach_pkg::US_W-1:0];
                r_quo <= {r_quo[etach_pkg::RPM_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[etach_pkg::US_W-2:0], r_quo[etach_pkg::RPM_W-1]};
                r_quo <= {r_quo[etach_pkg::RPM_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status <= i_cmd.out_status;
            case (i_cmd.out_status)
                etach_pkg::STATUS_NEW:  r_rpm <= r_quo;
                etach_pkg::STATUS_HELD: r_rpm <= r_last;
                default:                r_rpm <= '0;
            endcase
        end
    end

endmodule

[tb/sv/encoder_period_tachometer_tb.sv]
// testbench for the period-measuring tachometer: random and directed requests against a predictor
module encoder_period_tachometer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import etach_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HIGH1,
        PH_LOW1,
        PH_HIGH2,
        PH_LOW2
    } beam_wait_e;

    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] sample;
    } tach_request_t;

    typedef struct packed {
        logic [RPM_W-1:0]    rpm_q8;
        logic [STATUS_W-1:0] status;
    } speed_result_t;

    localparam longint unsigned SCALED_RPM_US = 64'd7680000000;
    localparam longint unsigned SHORTEST_US   = 64'd6000;
    localparam int              SAMPLE_TOP    = 1023;
    localparam int              DRAIN_CYCLES  = 30;
    localparam int              HOLD_CYCLES   = 400;
    localparam int              MAX_REPORTS   = 10;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    etach_in_if  in_bus ();
    etach_out_if out_bus ();

    encoder_period_tachometer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    tach_request_t pending_requests[$];
    speed_result_t expected_speeds[$];
    int            mismatch_cnt = 0;
    logic          steady_flow  = 1'b0;
    logic          hold_req     = 1'b0;
    logic          hold_ack     = 1'b0;
    int            hold_left    = 0;

    beam_wait_e             wait_ph     = PH_IDLE;
    logic [ELAPSED_W-1:0]   elapsed     = '0;
    logic [TIMER_BITS-1:0]  period      = '0;
    logic [RPM_W-1:0]       last_rpm    = '0;
    logic [THRESH_W-1:0]    thr_cfg     = THRESH_RST;
    logic [TIMEOUT_W-1:0]   timeout_cfg = TIMEOUT_RST;

    function automatic void track_request(logic kind, logic [SAMPLE_W-1:0] sample);
        logic [ELAPSED_W-1:0] ticks_before;
        logic                 stay;
        longint unsigned      period_us;
        speed_result_t        res;
        if (kind == KIND_START) begin
            wait_ph = PH_HIGH1;
            elapsed = '0;
            period  = '0;
            return;
        end
        if (wait_ph == PH_IDLE)
            return;
        ticks_before = elapsed;
        if (elapsed != ELAPSED_MAX)
            elapsed = elapsed + 1'b1;
        if (wait_ph >= PH_HIGH2 && period != TIMER_MAX)
            period = period + 1'b1;
        if (wait_ph == PH_HIGH1 || wait_ph == PH_HIGH2)
            stay = sample > thr_cfg;
        else
            stay = sample < thr_cfg;
        if (stay) begin
            if (ticks_before >= timeout_cfg) begin
                res.rpm_q8 = '0;
                res.status = STATUS_TIMEOUT;
                expected_speeds.push_back(res);
                wait_ph = PH_IDLE;
            end
            return;
        end
        if (wait_ph == PH_LOW1)
            period = '0;
        if (wait_ph == PH_LOW2) begin
            period_us = longint'(period) * TICK_US;
            if (period_us < SHORTEST_US) begin
                res.status = STATUS_HELD;
            end else begin
                last_rpm   = RPM_W'(SCALED_RPM_US / period_us);
                res.status = STATUS_NEW;
            end
            res.rpm_q8 = last_rpm;
            expected_speeds.push_back(res);
            wait_ph = PH_IDLE;
            return;
        end
        wait_ph = beam_wait_e'(wait_ph + 3'd1);
    endfunction

    always @(posedge i_clk) begin
        tach_request_t req_next;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready)
                track_request(in_bus.kind, in_bus.sample);
            if (!in_bus.valid || in_bus.ready) begin
                if (pending_requests.size() != 0 && (steady_flow || $urandom_range(99) >= 29)) begin
                    req_next = pending_requests.pop_front();
                    in_bus.valid  <= 1'b1;
                    in_bus.kind   <= req_next.kind;
                    in_bus.sample <= req_next.sample;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver stall on request
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        speed_result_t want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (expected_speeds.size() == 0) begin
                    if (mismatch_cnt < MAX_REPORTS)
                        $display("result with none expected: rpm_q8 %0d status %0d",
                                 out_bus.rpm_q8, out_bus.status);
                    mismatch_cnt++;
                end else begin
                    want = expected_speeds.pop_front();
                    if (out_bus.rpm_q8 !== want.rpm_q8 || out_bus.status !== want.status) begin
                        if (mismatch_cnt < MAX_REPORTS)
                            $display("speed mismatch: expected rpm_q8 %0d status %0d, got %0d %0d",
                                     want.rpm_q8, want.status, out_bus.rpm_q8, out_bus.status);
                        mismatch_cnt++;
                    end
                end
            end
            out_bus.ready <= (hold_left == 0) && (steady_flow || $urandom_range(99) >= 29);
        end
    end

    function automatic void push_request(logic kind, int sample);
        tach_request_t req;
        req.kind   = kind;
        req.sample = SAMPLE_W'(sample);
        pending_requests.push_back(req);
    endfunction

    function automatic logic is_high_wait(beam_wait_e w);
        return w == PH_HIGH1 || w == PH_HIGH2;
    endfunction

    function automatic logic can_stay(beam_wait_e w);
        return is_high_wait(w) ? (int'(thr_cfg) != SAMPLE_TOP) : (thr_cfg != '0);
    endfunction

    function automatic int stay_sample(beam_wait_e w);
        if (is_high_wait(w))
            return $urandom_range(SAMPLE_TOP, int'(thr_cfg) + 1);
        return $urandom_range(int'(thr_cfg) - 1, 0);
    endfunction

    function automatic int exit_sample(beam_wait_e w);
        if ($urandom_range(99) < 20)
            return int'(thr_cfg);
        if (is_high_wait(w))
            return $urandom_range(int'(thr_cfg), 0);
        return $urandom_range(SAMPLE_TOP, int'(thr_cfg));
    endfunction

    function automatic int push_measurement(int s1, int s2, int s3, int s4);
        int         stays[4];
        int         cnt;
        beam_wait_e w;
        stays = '{s1, s2, s3, s4};
        push_request(KIND_START, $urandom_range(SAMPLE_TOP));
        cnt = 1;
        for (int i = 0; i < 4; i++) begin
            w = beam_wait_e'(i + 1);
            if (can_stay(w)) begin
                repeat (stays[i]) push_request(KIND_TICK, stay_sample(w));
                cnt += stays[i];
            end
            push_request(KIND_TICK, exit_sample(w));
            cnt++;
        end
        return cnt;
    endfunction

    // period in ticks between the start and end marks
    function automatic void push_long(int ticks);
        int s3;
        if (!can_stay(PH_HIGH2))
            s3 = 0;
        else if (!can_stay(PH_LOW2))
            s3 = ticks - 2;
        else
            s3 = $urandom_range(ticks - 2, 0);
        void'(push_measurement($urandom_range(3), $urandom_range(3), s3, ticks - 2 - s3));
    endfunction

    function automatic int short_stay();
        return ($urandom_range(99) < 85) ? $urandom_range(3) : $urandom_range(40, 4);
    endfunction

    function automatic void push_random_traffic(int n);
        int done;
        int r;
        int k;
        done = 0;
        while (done < n) begin
            r = $urandom_range(99);
            if (r < 75) begin
                done += push_measurement(short_stay(), short_stay(), short_stay(), short_stay());
            end else if (r < 90) begin
                push_request(KIND_START, $urandom_range(SAMPLE_TOP));
                k = $urandom_range(6);
                repeat (k) push_request(KIND_TICK, $urandom_range(SAMPLE_TOP));
                done += k + 1;
            end else begin
                repeat ($urandom_range(3, 1)) push_request(KIND_TICK, $urandom_range(SAMPLE_TOP));
            end
        end
    endfunction

    task automatic wait_idle();
        while (pending_requests.size() != 0 || in_bus.valid || expected_speeds.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic set_config(int thr, int tmo);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_TIMEOUT, tmo);
        thr_cfg     = THRESH_W'(thr);
        timeout_cfg = TIMEOUT_W'(tmo);
    endtask

    initial begin
        in_bus.valid  = 1'b0;
        in_bus.kind   = KIND_START;
        in_bus.sample = '0;
        out_bus.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // tick while idle, then equal-threshold exits and extremes with a short period
        push_request(KIND_TICK, SAMPLE_TOP);
        push_request(KIND_START, SAMPLE_TOP);
        push_request(KIND_TICK, SAMPLE_TOP);
        push_request(KIND_TICK, 512);
        push_request(KIND_TICK, 0);
        push_request(KIND_TICK, 512);
        push_request(KIND_TICK, 513);
        push_request(KIND_TICK, 511);
        push_request(KIND_TICK, 0);
        push_request(KIND_TICK, SAMPLE_TOP);
        // restart while running
        push_request(KIND_START, 0);
        push_request(KIND_TICK, SAMPLE_TOP);
        push_request(KIND_START, 0);
        push_request(KIND_TICK, 511);
        push_request(KIND_TICK, 513);
        push_request(KIND_TICK, 0);
        push_request(KIND_TICK, SAMPLE_TOP);
        // fastest full speed, then just too fast
        push_long(6000);
        push_long(5999);
        wait_idle();

        set_config(0, 1);
        void'(push_measurement(3, 0, 0, 0));
        push_random_traffic(250);
        wait_idle();

        set_config(SAMPLE_TOP, 24'hFFFFFF);
        push_random_traffic(250);
        wait_idle();

        set_config($urandom_range(SAMPLE_TOP - 1, 1), $urandom_range(30, 2));
        push_random_traffic(150);
        @(posedge i_clk);
        hold_req <= ~hold_req;
        push_random_traffic(150);
        wait_idle();
        push_random_traffic(150);
        wait_idle();

        set_config($urandom_range(SAMPLE_TOP - 1, 1), TIMEOUT_RST);
        @(posedge i_clk);
        steady_flow <= 1'b1;
        push_random_traffic(200);
        wait_idle();
        steady_flow <= 1'b0;
        push_long($urandom_range(9000, 6001));
        push_random_traffic(100);
        wait_idle();

        set_config($urandom_range(SAMPLE_TOP), $urandom_range(60, 1));
        push_random_traffic(250);
        wait_idle();

        if (mismatch_cnt == 0 && expected_speeds.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
